// ===== sv/u16u8_pkg.sv =====
// Shared types and encoding helpers for the UTF-16 to UTF-8 transcoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package u16u8_pkg;

  // Default depth of the job queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Surrogate prefixes (upper six bits of a code unit)
  localparam logic [5:0] HIGH_SURR_PFX = 6'b110110;
  localparam logic [5:0] LOW_SURR_PFX  = 6'b110111;

  // Base of the supplementary planes
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Encoded length codes (byte count minus one)
  localparam logic [1:0] LEN_ONE   = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

  // Input item: one UTF-16 code unit
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  // Result item: one UTF-8 byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;
  } out_item_t;

  // Job handed from front to back: one or two code points to encode
  typedef struct packed {
    logic [20:0] point_a;
    logic        has_b;
    logic [15:0] point_b;
    logic        last;
  } job_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
  } q_stat_t;

  // Byte count minus one for a code point
  function automatic logic [1:0] utf8_len(input logic [20:0] c);
    logic [1:0] n;
    if (c < 21'h80) begin
      n = LEN_ONE;
    end else if (c < 21'h800) begin
      n = LEN_TWO;
    end else if (c < 21'h10000) begin
      n = LEN_THREE;
    end else begin
      n = LEN_FOUR;
    end
    return n;
  endfunction

  // Byte k of the encoding of c
  function automatic logic [7:0] utf8_byte(input logic [20:0] c, input logic [1:0] k);
    logic [7:0] b;
    b = 8'h00;
    case (utf8_len(c))
      LEN_ONE: begin
        b = {1'b0, c[6:0]};
      end
      LEN_TWO: begin
        b = (k == 2'd0) ? {3'b110, c[10:6]} : {2'b10, c[5:0]};
      end
      LEN_THREE: begin
        case (k)
          2'd0:    b = {4'b1110, c[15:12]};
          2'd1:    b = {2'b10, c[11:6]};
          default: b = {2'b10, c[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    b = {5'b11110, c[20:18]};
          2'd1:    b = {2'b10, c[17:12]};
          2'd2:    b = {2'b10, c[11:6]};
          default: b = {2'b10, c[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ===== sv/utf16_to_utf8_transcode.sv =====
// UTF-16 to UTF-8 transcoder: one code unit in, zero to six bytes out per item.
// An item's first byte passes the job queue, then the back end's output register.
// Throughput: one item per cycle while each yields one byte and out_stall is low;
// else the back end sets one byte per unstalled cycle, with QUEUE_DEPTH jobs buffered.
// Reset (rst_n, synchronous): drops any held surrogate, empties the queue.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
module utf16_to_utf8_transcode #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  u16u8_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u16u8_pkg::out_item_t out_item
);

  u16u8_pkg::q_stat_t q_stat;
  u16u8_pkg::job_t    push_job;
  u16u8_pkg::job_t    head_job;
  logic               push;
  logic               pop;
  logic               head_valid;

  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .q_stat     (q_stat),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ===== sv/u16u8_front.sv =====
// Front end: accepts code units, tracks a held high surrogate and builds jobs.
// Depends on u16u8_pkg for item and job types.
module u16u8_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  u16u8_pkg::in_item_t  in_item,
  input  u16u8_pkg::q_stat_t   q_stat,
  output logic                 push,
  output u16u8_pkg::job_t      push_job
);

  logic       pend_valid_r, pend_valid_nxt;
  logic [9:0] pend_high_r, pend_high_nxt;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       hold_new;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // Classify the incoming unit
  assign is_high  = in_item.code_unit[15:10] == u16u8_pkg::HIGH_SURR_PFX;
  assign is_low   = in_item.code_unit[15:10] == u16u8_pkg::LOW_SURR_PFX;
  assign hold_new = is_high && !in_item.last_unit;

  // Build the job and next surrogate state
  always_comb begin
    push_job.point_a = '0;
    push_job.has_b   = 1'b0;
    push_job.point_b = in_item.code_unit;
    push_job.last    = in_item.last_unit;
    push             = 1'b0;
    pend_valid_nxt   = pend_valid_r;
    pend_high_nxt    = pend_high_r;
    if (accept) begin
      if (pend_valid_r && is_low) begin
        push_job.point_a = u16u8_pkg::SUPP_BASE
                         + {1'b0, pend_high_r, in_item.code_unit[9:0]};
        push             = 1'b1;
        pend_valid_nxt   = 1'b0;
        pend_high_nxt    = '0;
      end else if (pend_valid_r) begin
        push_job.point_a = {5'd0, u16u8_pkg::HIGH_SURR_PFX, pend_high_r};
        push_job.has_b   = !hold_new;
        push             = 1'b1;
        pend_valid_nxt   = hold_new;
        pend_high_nxt    = hold_new ? in_item.code_unit[9:0] : 10'd0;
      end else begin
        push_job.point_a = {5'd0, in_item.code_unit};
        push             = !hold_new;
        pend_valid_nxt   = hold_new;
        pend_high_nxt    = hold_new ? in_item.code_unit[9:0] : 10'd0;
      end
    end
  end

  // Hold surrogate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_high_r  <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      pend_high_r  <= pend_high_nxt;
    end
  end

endmodule

// ===== sv/u16u8_queue.sv =====
// Job queue between front and back, a small register FIFO.
// Depends on u16u8_pkg for the job type; DEPTH must be at least 2.
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u16u8_pkg::job_t     push_job,
  output u16u8_pkg::q_stat_t  q_stat,
  input  logic                pop,
  output logic                head_valid,
  output u16u8_pkg::job_t     head_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  u16u8_pkg::job_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full = cnt_r == CNT_FULL;
  assign head_valid  = cnt_r != '0;
  assign head_job    = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== sv/u16u8_back.sv =====
// Back end: serializes each job into UTF-8 bytes, one per cycle while not stalled.
// Depends on u16u8_pkg for the job and result types and encoding functions.
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  u16u8_pkg::job_t      head_job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u16u8_pkg::out_item_t out_item
);

  logic                 seg_r, seg_nxt;
  logic [1:0]           idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  u16u8_pkg::out_item_t out_item_r, out_item_nxt;
  logic                 load;
  logic [20:0]          cur_point;
  logic                 last_byte;
  logic                 final_byte;

  assign load       = head_valid && (!out_valid_r || !out_stall);
  assign cur_point  = seg_r ? {5'd0, head_job.point_b} : head_job.point_a;
  assign last_byte  = idx_r == u16u8_pkg::utf8_len(cur_point);
  assign final_byte = last_byte && (seg_r || !head_job.has_b);
  assign pop        = load && final_byte;

  // Step through bytes and points of the head job
  always_comb begin
    seg_nxt       = seg_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (load) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.out_byte = u16u8_pkg::utf8_byte(cur_point, idx_r);
      out_item_nxt.run_end  = final_byte;
      out_item_nxt.text_end = final_byte && head_job.last;
      if (last_byte) begin
        idx_nxt = '0;
        seg_nxt = !final_byte;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seg_r       <= seg_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the output byte until taken
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sim/tb_utf16_to_utf8_transcode.sv =====
// Testbench for utf16_to_utf8_transcode: random and directed UTF-16 text, bytes checked
// in order against a surrogate-aware UTF-8 encoder kept in a small scoreboard class.
// Depends on u16u8_pkg and the utf16_to_utf8_transcode top level.
module tb_utf16_to_utf8_transcode;

  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;

  // Track held surrogates and the bytes still owed by the block
  class utf8_tracker;
    u16u8_pkg::out_item_t expected_bytes[$];
    logic [9:0] held_high;
    bit         held;
    int         units_seen;
    int         bytes_checked;
    int         pairs_joined;
    int         errors;

    function void push_byte(logic [7:0] v);
      u16u8_pkg::out_item_t b;
      b = '0;
      b.out_byte = v;
      expected_bytes.push_back(b);
    endfunction

    // Append the UTF-8 bytes of one code point
    function void append_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
        push_byte({1'b0, cp[6:0]});
      end else if (cp < 21'h800) begin
        push_byte(8'hC0 | 8'(cp >> 6));
        push_byte(8'h80 | 8'(cp & 21'h3F));
      end else if (cp < 21'h10000) begin
        push_byte(8'hE0 | 8'(cp >> 12));
        push_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
        push_byte(8'h80 | 8'(cp & 21'h3F));
      end else begin
        push_byte(8'hF0 | 8'(cp >> 18));
        push_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
        push_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
        push_byte(8'h80 | 8'(cp & 21'h3F));
      end
    endfunction

    // Predict the bytes caused by one accepted unit
    function void note_unit(u16u8_pkg::in_item_t it);
      int          start;
      logic [15:0] u;
      bit          is_high;
      bit          is_low;
      u16u8_pkg::out_item_t tail;
      u = it.code_unit;
      start = expected_bytes.size();
      is_high = (u[15:10] == u16u8_pkg::HIGH_SURR_PFX);
      is_low = (u[15:10] == u16u8_pkg::LOW_SURR_PFX);
      units_seen++;
      if (held && is_low) begin
        append_utf8(u16u8_pkg::SUPP_BASE + {1'b0, held_high, u[9:0]});
        held = 0;
        pairs_joined++;
      end else begin
        // flush a held high surrogate as itself
        if (held) begin
          append_utf8({5'b0, u16u8_pkg::HIGH_SURR_PFX, held_high});
          held = 0;
        end
        if (is_high && !it.last_unit) begin
          held_high = u[9:0];
          held = 1;
        end else begin
          append_utf8({5'b0, u});
        end
      end
      // mark the closing byte of this item
      if (expected_bytes.size() > start) begin
        tail = expected_bytes.pop_back();
        tail.run_end = 1'b1;
        tail.text_end = it.last_unit;
        expected_bytes.push_back(tail);
      end
    endfunction

    function void report(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // Compare one accepted byte with the oldest expectation
    function void check_byte(u16u8_pkg::out_item_t got);
      u16u8_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, actual %02h run_end %b text_end %b",
                 $time, got.out_byte, got.run_end, got.text_end);
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
        if (got.run_end !== want.run_end) report("run_end", want.run_end, got.run_end);
        if (got.text_end !== want.text_end) report("text_end", want.text_end, got.text_end);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  u16u8_pkg::in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  u16u8_pkg::out_item_t out_item;

  logic        hold_req = 1'b0;
  int          send_idle_pct;
  int          recv_idle_pct;
  utf8_tracker board = new;

  utf16_to_utf8_transcode dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one unit, with a random gap first, and hold it until accepted
  task automatic send_unit(input logic [15:0] code, input logic last);
    u16u8_pkg::in_item_t it;
    it.code_unit = code;
    it.last_unit = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_unit(it);
  endtask

  // Send random text; well-formed pairs are a quarter of picks, lone surrogates and noise mixed in
  task automatic send_random_text(input int count);
    int          sent;
    int          pick;
    logic        last;
    logic [15:0] u;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      last = ($urandom_range(9) == 0);
      if (pick < 25) begin
        send_unit(16'($urandom_range(16'h007F, 0)), last);
      end else if (pick < 38) begin
        send_unit(16'($urandom_range(16'h07FF, 16'h0080)), last);
      end else if (pick < 52) begin
        if ($urandom_range(1) == 1) u = 16'($urandom_range(16'hD7FF, 16'h0800));
        else u = 16'($urandom_range(16'hFFFF, 16'hE000));
        send_unit(u, last);
      end else if (pick < 77) begin
        send_unit(16'($urandom_range(16'hDBFF, 16'hD800)), 1'b0);
        send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), last);
        sent++;
      end else if (pick < 84) begin
        send_unit(16'($urandom_range(16'hDBFF, 16'hD800)), last);
      end else if (pick < 90) begin
        send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), last);
      end else begin
        send_unit(16'($urandom_range(16'hFFFF, 0)), last);
      end
      sent++;
    end
  endtask

  // Receiver: check accepted bytes, stall at random, hold off once on request
  initial begin : receiver
    int  held_cycles;
    bit  hold_done;
    held_cycles = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_byte(out_item);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        held_cycles++;
        if (held_cycles == HOLD_CYCLES) hold_done = 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: give up when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("utf16_to_utf8_transcode: mismatch");
    $finish;
  end

  initial begin : main
    send_idle_pct = 8;
    recv_idle_pct = 66;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: range edges, pairs, lone surrogates, flushes
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hD912, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hDA00, 1'b0);
    send_unit(16'hDB00, 1'b0);
    send_unit(16'hDC55, 1'b0);
    send_unit(16'hDABC, 1'b1);
    send_unit(16'hD801, 1'b0);
    send_unit(16'h07FF, 1'b1);
    send_unit(16'hD8FF, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD840, 1'b0);
    send_unit(16'h0000, 1'b1);

    send_random_text(100);
    send_idle_pct = 66;
    recv_idle_pct = 8;
    send_random_text(100);
    // No idling; receiver holds off long enough to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    send_random_text(100);
    in_valid <= 1'b0;

    // Drain, then allow for stray bytes
    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d units (%0d surrogate pairs) and %0d output bytes,",
             board.units_seen, board.pairs_joined, board.bytes_checked);
    $display("across sender-idle, receiver-idle, no-idle and long back-pressure phases.");
    if (board.errors == 0) begin
      $display("utf16_to_utf8_transcode: match");
    end else begin
      $display("utf16_to_utf8_transcode: mismatch");
    end
    $finish;
  end

endmodule
